FILE: rtl/fmtt_pkg.sv
// ----------------------------------------------------------------------------
// fmtt_pkg
// Shared widths, operation codes and controller/datapath interface types for
// the frame milestone timestamp table.
// ----------------------------------------------------------------------------
package fmtt_pkg;

  // Default ring depth
  localparam int CAPACITY_DEF = 64;

  // Milestones per record
  localparam int NMILE = 6;

  // Field widths
  localparam int FUNC_W  = 3;
  localparam int KEY_W   = 64;
  localparam int DISP_W  = 8;
  localparam int LAYER_W = 3;
  localparam int TIME_W  = 64;
  localparam int SLOT_W  = 6;
  localparam int MILE_W  = 3;

  // Stream widths
  localparam int S_TDATA_W = 144;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 152;
  localparam int M_TUSER_W = 5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_SUBMIT     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUEUE      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCHEDULE   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PRESENT    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DISPLAY    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_COMPLETION = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_QUERY_KEY  = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_QUERY_NEW  = 3'd7;

  // Result kinds loaded into the output register
  localparam logic [1:0] EMIT_OK    = 2'd0;
  localparam logic [1:0] EMIT_MISS  = 2'd1;
  localparam logic [1:0] EMIT_QUERY = 2'd2;

  // Last milestone index
  localparam logic [MILE_W-1:0] MILE_LAST = MILE_W'(NMILE - 1);

  // Stored record body
  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [DISP_W-1:0]  disp;
    logic [KEY_W-1:0]   key;
  } rec_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;      // latch a new transaction, arm the scan
    logic       newest;    // select the newest slot
    logic       search;    // advance the key scan
    logic       claim;     // take the slot at the write pointer
    logic       wr_mile;   // write one milestone time
    logic       wr_create; // write the milestone row of a new record
    logic       mstep;     // advance the milestone counter
    logic       emit;      // load the output register
    logic [1:0] emit_kind;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              fill_zero;
    logic              hit;
    logic              miss;
    logic              mcnt_last;
    logic              out_free;
  } stat_t;

endpackage

FILE: rtl/fmtt_dp.sv
// ----------------------------------------------------------------------------
// fmtt_dp
// Datapath: record and milestone memories, ring pointer and fill count,
// sequential key scan and the output register.
// ----------------------------------------------------------------------------
module fmtt_dp
  import fmtt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [DISP_W-1:0]    in_disp,
  input  logic [LAYER_W-1:0]   in_layer,
  input  logic [TIME_W-1:0]    in_time,
  input  logic                 m_ready,
  output logic                 m_valid,
  output logic                 o_status,
  output logic [SLOT_W-1:0]    o_slot,
  output logic                 o_created,
  output logic [MILE_W-1:0]    o_mile,
  output logic [TIME_W-1:0]    o_time,
  output logic [KEY_W-1:0]     o_key,
  output logic [DISP_W-1:0]    o_disp,
  output logic [LAYER_W-1:0]   o_layer,
  output logic                 o_last
);

  localparam int PTR_W   = $clog2(CAPACITY);
  localparam int FILL_W  = $clog2(CAPACITY + 1);
  localparam int TDEPTH  = CAPACITY * NMILE;
  localparam int TADDR_W = $clog2(TDEPTH);
  localparam logic [PTR_W-1:0]  PTR_MAX  = PTR_W'(CAPACITY - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);

  // Memories
  rec_t              rec_mem [CAPACITY];
  logic [TIME_W-1:0] time_mem [TDEPTH];

  // Transaction registers
  logic [FUNC_W-1:0]  func;
  logic [KEY_W-1:0]   key;
  logic [DISP_W-1:0]  disp;
  logic [LAYER_W-1:0] layer;
  logic [TIME_W-1:0]  tstamp;

  // Ring state
  logic [PTR_W-1:0]  wp;
  logic [FILL_W-1:0] fill;

  // Scan state
  logic [PTR_W-1:0]  scan_addr;
  logic [FILL_W-1:0] scan_cnt;
  logic              pend_vld;
  logic [PTR_W-1:0]  pend_addr;
  logic              pend_last;

  // Working slot and milestone counter
  logic [PTR_W-1:0]  slot;
  logic              created;
  logic [MILE_W-1:0] mcnt;

  // Memory ports
  logic [PTR_W-1:0]   rec_raddr;
  rec_t               rec_rdata;
  logic [TADDR_W-1:0] tbase;
  logic [TADDR_W-1:0] t_raddr;
  logic [TADDR_W-1:0] t_waddr;
  logic [TIME_W-1:0]  t_wdata;
  logic               t_we;
  logic [TIME_W-1:0]  t_rdata;

  logic [PTR_W-1:0] wp_dec;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] scan_dec;
  logic             issue;
  logic             match;

  // Ring arithmetic
  assign wp_dec   = (wp == '0) ? PTR_MAX : wp - PTR_W'(1);
  assign wp_inc   = (wp == PTR_MAX) ? '0 : wp + PTR_W'(1);
  assign scan_dec = (scan_addr == '0) ? PTR_MAX : scan_addr - PTR_W'(1);

  // Scan compare on the registered read
  assign issue = cmd.search && (scan_cnt < fill);
  assign match = pend_vld && (rec_rdata.key == key);

  // Status toward the controller
  assign stat.func      = func;
  assign stat.fill_zero = (fill == '0);
  assign stat.hit       = match;
  assign stat.miss      = pend_vld && pend_last && !match;
  assign stat.mcnt_last = (mcnt == MILE_LAST);
  assign stat.out_free  = !m_valid || m_ready;

  // Latch the transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func   <= in_func;
      key    <= in_key;
      disp   <= in_disp;
      layer  <= in_layer;
      tstamp <= in_time;
    end
  end

  // Advance write pointer and fill count on a claim
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (cmd.claim) begin
      wp <= wp_inc;
      if (fill != FILL_MAX) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

  // Walk the ring from the newest slot back
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (cmd.load) begin
      pend_vld <= 1'b0;
    end else if (cmd.search) begin
      pend_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_addr <= wp_dec;
      scan_cnt  <= '0;
    end else if (issue) begin
      scan_addr <= scan_dec;
      scan_cnt  <= scan_cnt + FILL_W'(1);
    end
    if (cmd.search) begin
      pend_addr <= scan_addr;
      pend_last <= (scan_cnt == fill - FILL_W'(1));
    end
  end

  // Select the working slot
  always_ff @(posedge clk) begin
    if (cmd.search && match) begin
      slot <= pend_addr;
    end else if (cmd.newest) begin
      slot <= wp_dec;
    end else if (cmd.claim) begin
      slot <= wp;
    end
    if (cmd.load) begin
      created <= 1'b0;
    end else if (cmd.claim) begin
      created <= 1'b1;
    end
    if (cmd.load) begin
      mcnt <= '0;
    end else if (cmd.mstep || cmd.wr_create) begin
      mcnt <= mcnt + MILE_W'(1);
    end
  end

  // Record memory: written on a claim, read every cycle
  assign rec_raddr = cmd.search ? scan_addr : slot;

  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      rec_mem[wp] <= '{layer: layer, disp: disp, key: key};
    end
    rec_rdata <= rec_mem[rec_raddr];
  end

  // Milestone memory, one row of NMILE entries per slot
  assign tbase   = TADDR_W'(slot) * TADDR_W'(NMILE);
  assign t_raddr = tbase + TADDR_W'(mcnt);
  assign t_waddr = cmd.wr_mile ? tbase + TADDR_W'(func) : t_raddr;
  assign t_we    = cmd.wr_mile || cmd.wr_create;
  assign t_wdata = (cmd.wr_mile || mcnt == '0) ? tstamp : '0;

  always_ff @(posedge clk) begin
    if (t_we) begin
      time_mem[t_waddr] <= t_wdata;
    end
    t_rdata <= time_mem[t_raddr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.emit) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_kind)
        EMIT_QUERY: begin
          o_status  <= 1'b0;
          o_slot    <= SLOT_W'(slot);
          o_created <= 1'b0;
          o_mile    <= mcnt;
          o_time    <= t_rdata;
          o_key     <= rec_rdata.key;
          o_disp    <= rec_rdata.disp;
          o_layer   <= rec_rdata.layer;
          o_last    <= (mcnt == MILE_LAST);
        end
        EMIT_MISS: begin
          o_status  <= 1'b1;
          o_slot    <= '0;
          o_created <= 1'b0;
          o_mile    <= '0;
          o_time    <= '0;
          o_key     <= '0;
          o_disp    <= '0;
          o_layer   <= '0;
          o_last    <= 1'b1;
        end
        default: begin
          o_status  <= 1'b0;
          o_slot    <= SLOT_W'(slot);
          o_created <= created;
          o_mile    <= '0;
          o_time    <= '0;
          o_key     <= '0;
          o_disp    <= '0;
          o_layer   <= '0;
          o_last    <= 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: rtl/fmtt_ctrl.sv
// ----------------------------------------------------------------------------
// fmtt_ctrl
// Controller: sequences dispatch, key scan, memory writes and result output
// for one transaction at a time.
// ----------------------------------------------------------------------------
module fmtt_ctrl
  import fmtt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DISP   = 4'd1;
  localparam logic [3:0] ST_SEARCH = 4'd2;
  localparam logic [3:0] ST_WRITE  = 4'd3;
  localparam logic [3:0] ST_CLAIM  = 4'd4;
  localparam logic [3:0] ST_CREATE = 4'd5;
  localparam logic [3:0] ST_RESP   = 4'd6;
  localparam logic [3:0] ST_MISS   = 4'd7;
  localparam logic [3:0] ST_QRD    = 4'd8;
  localparam logic [3:0] ST_QOUT   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       is_submit;
  logic       is_mile;

  assign in_ready  = (state == ST_IDLE);
  assign is_submit = (stat.func == FUNC_SUBMIT);
  assign is_mile   = (stat.func <= FUNC_COMPLETION);

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.emit_kind = EMIT_OK;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        if (stat.func == FUNC_QUERY_NEW) begin
          if (stat.fill_zero) begin
            state_next = ST_MISS;
          end else begin
            cmd.newest = 1'b1;
            state_next = ST_QRD;
          end
        end else if (stat.fill_zero) begin
          state_next = is_submit ? ST_CLAIM : ST_MISS;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.hit) begin
          state_next = is_mile ? ST_WRITE : ST_QRD;
        end else if (stat.miss) begin
          state_next = is_submit ? ST_CLAIM : ST_MISS;
        end
      end
      ST_WRITE: begin
        cmd.wr_mile = 1'b1;
        state_next  = ST_RESP;
      end
      ST_CLAIM: begin
        cmd.claim  = 1'b1;
        state_next = ST_CREATE;
      end
      ST_CREATE: begin
        cmd.wr_create = 1'b1;
        if (stat.mcnt_last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_MISS;
          state_next    = ST_IDLE;
        end
      end
      ST_QRD: begin
        state_next = ST_QOUT;
      end
      ST_QOUT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_QUERY;
          cmd.mstep     = 1'b1;
          state_next    = stat.mcnt_last ? ST_IDLE : ST_QRD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/frame_milestone_timestamp_table.sv
// ----------------------------------------------------------------------------
// frame_milestone_timestamp_table
// Ring of frame records with six milestone timestamps each, searched by key
// from the newest record back.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Contents
//  s_*      in   tuser: func; tdata: frame key, display number, layer, timestamp
//  m_*      out  tuser: status, created, milestone; tdata: slot,
//                milestone_time, record_key, record_display, record_layer;
//                tlast: last
//
// One transaction at a time. The key scan reads one record per cycle for keyed
// milestone events, submits and queries by key. A submit that creates a record
// then claims a slot and makes six row writes; a query returns its results one
// at a time, each through a read state and an output state, for both the query
// by key and the query for the newest record.
// Reset is synchronous; it empties the ring by clearing the fill count, so
// no clearing pass is needed. A stalled result holds the output register and
// the next emit; the next transaction is taken as soon as the block is idle.
//
module frame_milestone_timestamp_table
  import fmtt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // frame key, display number, layer, timestamp
  input  logic [S_TUSER_W-1:0] s_tuser,  // func
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // slot, milestone_time, record_key,
                                         // record_display, record_layer
  output logic [M_TUSER_W-1:0] m_tuser,  // status, created, milestone
  output logic                 m_tlast
);

  cmd_t  cmd;
  stat_t stat;

  logic                status;
  logic [SLOT_W-1:0]   slot;
  logic                created;
  logic [MILE_W-1:0]   milestone;
  logic [TIME_W-1:0]   milestone_time;
  logic [KEY_W-1:0]    record_key;
  logic [DISP_W-1:0]   record_display;
  logic [LAYER_W-1:0]  record_layer;

  fmtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fmtt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (s_tuser[2:0]),
    .in_key    (s_tdata[63:0]),
    .in_disp   (s_tdata[71:64]),
    .in_layer  (s_tdata[74:72]),
    .in_time   (s_tdata[138:75]),
    .m_ready   (m_tready),
    .m_valid   (m_tvalid),
    .o_status  (status),
    .o_slot    (slot),
    .o_created (created),
    .o_mile    (milestone),
    .o_time    (milestone_time),
    .o_key     (record_key),
    .o_disp    (record_display),
    .o_layer   (record_layer),
    .o_last    (m_tlast)
  );

  // Pack the result
  assign m_tuser = {milestone, created, status};
  assign m_tdata = {7'd0, record_layer, record_display, record_key, milestone_time, slot};

endmodule

FILE: rtl/fmtt_checker.sv
// ----------------------------------------------------------------------------
// fmtt_checker
// Port-level checks on the result stream and input acceptance.
// ----------------------------------------------------------------------------
module fmtt_checker
  import fmtt_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser,
  input logic                 m_tlast
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Not-found result is a single, empty transaction
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == '0 && m_tuser[4:1] == '0)
    else $error("not-found result malformed");

  // New record result is single and ok
  a_create: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && m_tuser[4:2] == '0)
    else $error("created result malformed");

  // Only the final milestone of a query closes it (milestone zero is not checked)
  a_qlast: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4:2] != '0 && m_tuser[4:2] != MILE_LAST |-> !m_tlast)
    else $error("query closed early");

  // One transaction in work at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

endmodule

bind frame_milestone_timestamp_table fmtt_checker u_fmtt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
